// ===== src/seven_point_3d_stencil_defines.svh =====
// seven_point_3d_stencil_defines.svh: assertion macros for the stencil top level
// expects aclk and aresetn in the scope of use; no other dependencies
`ifndef SEVEN_POINT_3D_STENCIL_DEFINES_SVH
`define SEVEN_POINT_3D_STENCIL_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define STN7_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
    else $error("stn7 same-cycle check failed");

// next-cycle implication, disabled while in reset
`define STN7_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error("stn7 next-cycle check failed");

`endif

// ===== src/stn7_pkg.sv =====
// stn7_pkg: shared types, codes and weights of the seven-point stencil
// no dependencies; used by the plane store, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package stn7_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } cfg_idx_t;

    // input beat kinds
    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_DRAIN = 1'b1
    } act_t;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam int SIZE_XY_BITS  = 7;
    localparam int SIZE_Z_BITS   = 13;
    localparam int Z_BITS        = 12;
    localparam int SIZE_RESET    = 22;
    localparam int SIZE_MIN      = 3;
    localparam int PLANE_LIMIT   = 4096;
    localparam int FRAC_BITS     = 16;

    // q0.16 weights, sum 65535
    localparam logic [15:0] W_C  = 16'd51773;
    localparam logic [15:0] W_ZM = 16'd655;
    localparam logic [15:0] W_ZP = 16'd1311;
    localparam logic [15:0] W_YM = 16'd1966;
    localparam logic [15:0] W_YP = 16'd2621;
    localparam logic [15:0] W_XM = 16'd3277;
    localparam logic [15:0] W_XP = 16'd3932;

    // per-result flags carried down the pipe
    typedef struct packed {
        logic bnd;
        logic last;
    } meta_t;

    // plane store control for one cycle
    typedef struct packed {
        logic rd_en;
        logic rd_bank;
        logic wr_en;
        logic wr_bank;
    } store_ctl_t;

endpackage

`default_nettype wire

// ===== src/stn7_ram.sv =====
// stn7_ram: one-write two-read memory with registered read data, read-first
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module stn7_ram #(
    parameter int DATA_BITS = 32,
    parameter int DEPTH     = 4096,
    localparam int AW       = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr0,
    input  wire logic [AW-1:0]        rd_addr1,
    output logic      [DATA_BITS-1:0] rd_data0,
    output logic      [DATA_BITS-1:0] rd_data1
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data0 <= mem[rd_addr0];
            rd_data1 <= mem[rd_addr1];
        end
    end

endmodule

`default_nettype wire

// ===== src/stn7_plane_store.sv =====
// stn7_plane_store: two plane banks, each held in two copies for four reads a cycle
// depends on stn7_pkg and stn7_ram
`timescale 1ns / 1ps
`default_nettype none

module stn7_plane_store #(
    parameter int SAMPLE_BITS = 32,
    parameter int DEPTH       = 4096,
    localparam int AW         = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire stn7_pkg::store_ctl_t          ctl,
    input  wire logic [AW-1:0]                 addr_c,
    input  wire logic [AW-1:0]                 addr_xp,
    input  wire logic [AW-1:0]                 addr_ym,
    input  wire logic [AW-1:0]                 addr_yp,
    input  wire logic [SAMPLE_BITS-1:0]        wr_data,
    output logic signed [SAMPLE_BITS-1:0]      center,
    output logic signed [SAMPLE_BITS-1:0]      zm,
    output logic signed [SAMPLE_BITS-1:0]      xp,
    output logic signed [SAMPLE_BITS-1:0]      ym,
    output logic signed [SAMPLE_BITS-1:0]      yp
);

    logic [SAMPLE_BITS-1:0] a0 [2];
    logic [SAMPLE_BITS-1:0] a1 [2];
    logic [SAMPLE_BITS-1:0] b0 [2];
    logic [SAMPLE_BITS-1:0] b1 [2];
    logic                   cur_reg;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic we;
        assign we = ctl.wr_en && (ctl.wr_bank == 1'(b));

        // copy a: center and x+1
        stn7_ram #(.DATA_BITS(SAMPLE_BITS), .DEPTH(DEPTH)) u_copy_a (
            .aclk     (aclk),
            .wr_en    (we),
            .wr_addr  (addr_c),
            .wr_data  (wr_data),
            .rd_en    (ctl.rd_en),
            .rd_addr0 (addr_c),
            .rd_addr1 (addr_xp),
            .rd_data0 (a0[b]),
            .rd_data1 (a1[b])
        );

        // copy b: y-1 and y+1
        stn7_ram #(.DATA_BITS(SAMPLE_BITS), .DEPTH(DEPTH)) u_copy_b (
            .aclk     (aclk),
            .wr_en    (we),
            .wr_addr  (addr_c),
            .wr_data  (wr_data),
            .rd_en    (ctl.rd_en),
            .rd_addr0 (addr_ym),
            .rd_addr1 (addr_yp),
            .rd_data0 (b0[b]),
            .rd_data1 (b1[b])
        );
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            cur_reg <= ctl.rd_bank;
        end
    end

    // the other bank at the same address holds the plane below
    assign center = a0[cur_reg];
    assign zm     = a0[~cur_reg];
    assign xp     = a1[cur_reg];
    assign ym     = b0[cur_reg];
    assign yp     = b1[cur_reg];

endmodule

`default_nettype wire

// ===== src/stn7_datapath.sv =====
// stn7_datapath: weight products, sum, rounding, saturation and the result register
// depends on stn7_pkg
`timescale 1ns / 1ps
`default_nettype none

module stn7_datapath #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire stn7_pkg::meta_t              in_meta,
    input  wire logic signed [SAMPLE_BITS-1:0] c,
    input  wire logic signed [SAMPLE_BITS-1:0] zm,
    input  wire logic signed [SAMPLE_BITS-1:0] zp,
    input  wire logic signed [SAMPLE_BITS-1:0] ym,
    input  wire logic signed [SAMPLE_BITS-1:0] yp,
    input  wire logic signed [SAMPLE_BITS-1:0] xm,
    input  wire logic signed [SAMPLE_BITS-1:0] xp,
    output logic                              out_valid,
    output stn7_pkg::meta_t                   out_meta,
    output logic signed [SAMPLE_BITS-1:0]     out_value
);

    localparam int SW = SAMPLE_BITS + 17;
    localparam int FB = stn7_pkg::FRAC_BITS;

    localparam logic signed [16:0] K_C  = {1'b0, stn7_pkg::W_C};
    localparam logic signed [16:0] K_ZM = {1'b0, stn7_pkg::W_ZM};
    localparam logic signed [16:0] K_ZP = {1'b0, stn7_pkg::W_ZP};
    localparam logic signed [16:0] K_YM = {1'b0, stn7_pkg::W_YM};
    localparam logic signed [16:0] K_YP = {1'b0, stn7_pkg::W_YP};
    localparam logic signed [16:0] K_XM = {1'b0, stn7_pkg::W_XM};
    localparam logic signed [16:0] K_XP = {1'b0, stn7_pkg::W_XP};

    localparam logic signed [SW-1:0] HALF   = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SAMPLE_BITS+1){1'b0}},
                                               {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-SAMPLE_BITS+1){1'b1}},
                                               {(SAMPLE_BITS-1){1'b0}}};

    // product stage
    logic                          v2_reg;
    stn7_pkg::meta_t               meta2_reg;
    logic signed [SAMPLE_BITS-1:0] c2_reg;
    logic signed [SW-1:0]          p_c_reg, p_zm_reg, p_zp_reg, p_ym_reg;
    logic signed [SW-1:0]          p_yp_reg, p_xm_reg, p_xp_reg;

    // sum stage
    logic                          v3_reg;
    stn7_pkg::meta_t               meta3_reg;
    logic signed [SAMPLE_BITS-1:0] c3_reg;
    logic signed [SW-1:0]          sum3_reg;

    logic signed [SW-1:0]          rnd;
    logic signed [SW-1:0]          q;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic signed [SAMPLE_BITS-1:0] value_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else if (adv) begin
            v2_reg    <= in_valid;
            v3_reg    <= v2_reg;
            out_valid <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta2_reg <= in_meta;
            c2_reg    <= c;
            p_c_reg   <= SW'(c)  * SW'(K_C);
            p_zm_reg  <= SW'(zm) * SW'(K_ZM);
            p_zp_reg  <= SW'(zp) * SW'(K_ZP);
            p_ym_reg  <= SW'(ym) * SW'(K_YM);
            p_yp_reg  <= SW'(yp) * SW'(K_YP);
            p_xm_reg  <= SW'(xm) * SW'(K_XM);
            p_xp_reg  <= SW'(xp) * SW'(K_XP);

            meta3_reg <= meta2_reg;
            c3_reg    <= c2_reg;
            sum3_reg  <= p_c_reg + p_zm_reg + p_zp_reg + p_ym_reg
                       + p_yp_reg + p_xm_reg + p_xp_reg;

            out_meta  <= meta3_reg;
            out_value <= value_next;
        end
    end

    // round half up, then clamp to the sample range; boundary points keep the center
    always_comb begin
        rnd = sum3_reg + HALF;
        q   = rnd >>> FB;
        if (q > SAT_HI) begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (q < SAT_LO) begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat = q[SAMPLE_BITS-1:0];
        end
        value_next = meta3_reg.bnd ? c3_reg : sat;
    end

endmodule

`default_nettype wire

// ===== src/seven_point_3d_stencil.sv =====
// seven_point_3d_stencil: streaming seven-point 3d jacobi stencil, top level
// depends on stn7_pkg, stn7_plane_store, stn7_datapath, seven_point_3d_stencil_defines.svh
//
// channel  direction  ports                                   beat
// s_       in         s_valid s_ready s_action s_sample       one grid sample or a drain
// m_       out        m_valid m_ready m_value m_on_boundary   one updated point
//                     m_last
// cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  one register write
//
// one input beat per cycle while m_ does not stall; each result passes through the plane
// store read, the products, the sum and the result register, in that order
// a stall on m_ stops the whole pipe; s_ready is low only while a result waits unread
// reset clears the control state only; the plane store holds nothing valid until written
// and needs no clearing pass; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

`include "seven_point_3d_stencil_defines.svh"

module seven_point_3d_stencil #(
    parameter int MAX_ROW     = 64,
    parameter int MAX_ROWS    = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // input samples
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_action,
    input  wire logic signed [SAMPLE_BITS-1:0]         s_sample,
    // results
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [SAMPLE_BITS-1:0]              m_value,
    output logic                                       m_on_boundary,
    output logic                                       m_last,
    // register writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [stn7_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [stn7_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int PLANE_WORDS = MAX_ROW * MAX_ROWS;
    localparam int AW          = $clog2(PLANE_WORDS);
    localparam int XW          = $clog2(MAX_ROW);
    localparam int YW          = $clog2(MAX_ROWS);
    localparam int ZW          = stn7_pkg::Z_BITS;

    localparam int X_RST = (stn7_pkg::SIZE_RESET > MAX_ROW) ? MAX_ROW : stn7_pkg::SIZE_RESET;
    localparam int Y_RST = (stn7_pkg::SIZE_RESET > MAX_ROWS) ? MAX_ROWS : stn7_pkg::SIZE_RESET;
    localparam logic [XW-1:0] X_LAST_RST = XW'(X_RST - 1);
    localparam logic [YW-1:0] Y_LAST_RST = YW'(Y_RST - 1);
    localparam logic [ZW-1:0] Z_LAST_RST = ZW'(stn7_pkg::SIZE_RESET - 1);

    // ------------------------------------------------------------------
    // helpers: clamp a written size and keep its last index
    // ------------------------------------------------------------------
    function automatic logic [XW-1:0] x_last_of(input logic [stn7_pkg::SIZE_XY_BITS-1:0] v);
        int unsigned n;
        n = 32'(v);
        if (n < 32'(stn7_pkg::SIZE_MIN)) begin
            n = 32'(stn7_pkg::SIZE_MIN);
        end else if (n > 32'(MAX_ROW)) begin
            n = 32'(MAX_ROW);
        end
        return XW'(n - 32'd1);
    endfunction

    function automatic logic [YW-1:0] y_last_of(input logic [stn7_pkg::SIZE_XY_BITS-1:0] v);
        int unsigned n;
        n = 32'(v);
        if (n < 32'(stn7_pkg::SIZE_MIN)) begin
            n = 32'(stn7_pkg::SIZE_MIN);
        end else if (n > 32'(MAX_ROWS)) begin
            n = 32'(MAX_ROWS);
        end
        return YW'(n - 32'd1);
    endfunction

    function automatic logic [ZW-1:0] z_last_of(input logic [stn7_pkg::SIZE_Z_BITS-1:0] v);
        int unsigned n;
        n = 32'(v);
        if (n < 32'(stn7_pkg::SIZE_MIN)) begin
            n = 32'(stn7_pkg::SIZE_MIN);
        end else if (n > 32'(stn7_pkg::PLANE_LIMIT)) begin
            n = 32'(stn7_pkg::PLANE_LIMIT);
        end
        return ZW'(n - 32'd1);
    endfunction

    // in-plane word address, 0 past the plane; off-grid neighbors only ever serve faces
    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] ax, input logic [YW-1:0] ay);
        int unsigned lin;
        lin = 32'(ay) * 32'(MAX_ROW) + 32'(ax);
        return (lin < 32'(PLANE_WORDS)) ? AW'(lin) : '0;
    endfunction

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [XW-1:0] x_last_reg, x_last_next;
    logic [YW-1:0] y_last_reg, y_last_next;
    logic [ZW-1:0] z_last_reg, z_last_next;
    logic [XW-1:0] x_reg, x_next;       // position of the next result
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;
    logic          primed_reg, primed_next;   // first plane is in the store
    logic          done_reg, done_next;       // all samples of the grid are in

    // stage 1: store read data comes out alongside these
    logic                          s1_valid_reg;
    stn7_pkg::meta_t               s1_meta_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;   // the point one plane up
    logic signed [SAMPLE_BITS-1:0] left_reg;        // center of the previous result point

    logic adv;
    logic acc;
    logic is_push;
    logic do_prime;
    logic do_calc;
    logic do_drain;
    logic x_end;
    logic y_end;
    logic bnd0;
    logic restart;

    stn7_pkg::store_ctl_t          st_ctl;
    logic signed [SAMPLE_BITS-1:0] st_center, st_zm, st_xp, st_ym, st_yp;
    stn7_pkg::meta_t               out_meta;

    // the pipe moves whenever the result register is free or being taken
    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    assign acc     = s_valid && s_ready;
    assign is_push = stn7_pkg::act_t'(s_action) == stn7_pkg::ACT_PUSH;

    // beat classes: priming pushes only fill the store, pushes after the
    // last sample and drains before it are dropped without a result
    assign do_prime = acc && is_push && !done_reg && !primed_reg;
    assign do_calc  = acc && is_push && !done_reg && primed_reg;
    assign do_drain = acc && !is_push && done_reg;

    assign x_end = x_reg == x_last_reg;
    assign y_end = y_reg == y_last_reg;
    assign bnd0  = (x_reg == '0) || (y_reg == '0) || (z_reg == '0)
                || x_end || y_end || (z_reg == z_last_reg);

    always_comb begin
        x_last_next = x_last_reg;
        y_last_next = y_last_reg;
        z_last_next = z_last_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        primed_next = primed_reg;
        done_next   = done_reg;
        restart     = 1'b0;

        // walk x, then y, on every beat that does work
        if (do_prime || do_calc || do_drain) begin
            if (x_end) begin
                x_next = '0;
                y_next = y_end ? '0 : y_reg + YW'(1);
            end else begin
                x_next = x_reg + XW'(1);
            end
        end

        if (do_prime && x_end && y_end) begin
            primed_next = 1'b1;
        end

        // plane done: move up; the plane before the top face ends the input
        if (do_calc && x_end && y_end) begin
            z_next = z_reg + ZW'(1);
            if ({1'b0, z_reg} + (ZW+1)'(1) >= {1'b0, z_last_reg}) begin
                done_next = 1'b1;
            end
        end

        // final point drained: ready for a new grid
        if (do_drain && x_end && y_end) begin
            restart = 1'b1;
        end

        // a write to a size register restarts the stream
        if (cfg_valid && cfg_ready) begin
            case (stn7_pkg::cfg_idx_t'(cfg_index))
                stn7_pkg::CFG_SIZE_X: begin
                    x_last_next = x_last_of(cfg_data[stn7_pkg::SIZE_XY_BITS-1:0]);
                    restart     = 1'b1;
                end
                stn7_pkg::CFG_SIZE_Y: begin
                    y_last_next = y_last_of(cfg_data[stn7_pkg::SIZE_XY_BITS-1:0]);
                    restart     = 1'b1;
                end
                stn7_pkg::CFG_SIZE_Z: begin
                    z_last_next = z_last_of(cfg_data);
                    restart     = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (restart) begin
            x_next      = '0;
            y_next      = '0;
            z_next      = '0;
            primed_next = 1'b0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_last_reg   <= X_LAST_RST;
            y_last_reg   <= Y_LAST_RST;
            z_last_reg   <= Z_LAST_RST;
            x_reg        <= '0;
            y_reg        <= '0;
            z_reg        <= '0;
            primed_reg   <= 1'b0;
            done_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            x_last_reg <= x_last_next;
            y_last_reg <= y_last_next;
            z_last_reg <= z_last_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            z_reg      <= z_next;
            primed_reg <= primed_next;
            done_reg   <= done_next;
            if (adv) begin
                s1_valid_reg <= st_ctl.rd_en;
            end
        end
    end

    // stage 1 payload; x-1 comes from the previous result point of the same row
    always_ff @(posedge aclk) begin
        if (st_ctl.rd_en) begin
            s1_meta_reg.bnd  <= do_drain || bnd0;
            s1_meta_reg.last <= do_drain && x_end && y_end;
            s1_sample_reg    <= s_sample;
            left_reg         <= st_center;
        end
    end

    // ------------------------------------------------------------------
    // plane store: current plane in bank z[0], the plane below in the
    // other bank, where new samples land once primed (read before write)
    // ------------------------------------------------------------------
    always_comb begin
        st_ctl.rd_en   = do_calc || do_drain;
        st_ctl.rd_bank = z_reg[0];
        st_ctl.wr_en   = do_prime || do_calc;
        st_ctl.wr_bank = primed_reg ? ~z_reg[0] : 1'b0;
    end

    stn7_plane_store #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DEPTH       (PLANE_WORDS)
    ) u_store (
        .aclk    (aclk),
        .ctl     (st_ctl),
        .addr_c  (addr_of(x_reg, y_reg)),
        .addr_xp (addr_of(x_reg + XW'(1), y_reg)),
        .addr_ym (addr_of(x_reg, y_reg - YW'(1))),
        .addr_yp (addr_of(x_reg, y_reg + YW'(1))),
        .wr_data (s_sample),
        .center  (st_center),
        .zm      (st_zm),
        .xp      (st_xp),
        .ym      (st_ym),
        .yp      (st_yp)
    );

    // ------------------------------------------------------------------
    // arithmetic and result register
    // ------------------------------------------------------------------
    stn7_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .in_meta   (s1_meta_reg),
        .c         (st_center),
        .zm        (st_zm),
        .zp        (s1_sample_reg),
        .ym        (st_ym),
        .yp        (st_yp),
        .xm        (left_reg),
        .xp        (st_xp),
        .out_valid (m_valid),
        .out_meta  (out_meta),
        .out_value (m_value)
    );

    assign m_on_boundary = out_meta.bnd;
    assign m_last        = out_meta.last;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `STN7_ASSERT_NEXT(a_last_restarts, do_drain && x_end && y_end, (x_reg == '0) && (y_reg == '0) && (z_reg == '0) && !primed_reg && !done_reg)
    `STN7_ASSERT_NEXT(a_drain_is_face, do_drain, s1_valid_reg && s1_meta_reg.bnd)
    `STN7_ASSERT_IMP(a_plane_in_range, 1'b1, z_reg <= z_last_reg)

endmodule

`default_nettype wire
